// File: design/aep_pkg.sv
// aep_pkg: widths, command and status codes and parameter defaults for the
// active/expired priority queue; no dependencies, compiled first
package aep_pkg;

  localparam int CFG_W   = 5;
  localparam int ID_W    = 8;
  localparam int DPRIO_W = 5;
  localparam int RPRIO_W = 4;
  localparam int OPRIO_W = 4;
  localparam int STAT_W  = 3;

  localparam int MAX_LEVELS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TASK_ID_BITS_DEF = 8;

  localparam logic [CFG_W-1:0]   LEVEL_COUNT_RST = CFG_W'(4);
  localparam logic [DPRIO_W-1:0] DPRIO_EXPIRED   = '1;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_GET = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_DISPATCHED = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_BADPRIO    = 3'd4
  } status_e;

endpackage

// File: design/aep_if.sv
// aep_if: valid/ready channel interfaces for request and result words
// depends on aep_pkg
interface aep_in_if;
  logic                          valid;
  logic                          ready;
  aep_pkg::cmd_e                 command;
  logic [aep_pkg::ID_W-1:0]      task_id;
  logic [aep_pkg::DPRIO_W-1:0]   dynamic_priority;
  logic [aep_pkg::RPRIO_W-1:0]   reset_priority;

  modport source (output valid, command, task_id, dynamic_priority, reset_priority,
                  input ready);
  modport sink   (input valid, command, task_id, dynamic_priority, reset_priority,
                  output ready);
endinterface

interface aep_out_if;
  logic                          valid;
  logic                          ready;
  aep_pkg::status_e              status;
  logic [aep_pkg::ID_W-1:0]      task_id_out;
  logic [aep_pkg::OPRIO_W-1:0]   priority_out;

  modport source (output valid, status, task_id_out, priority_out, input ready);
  modport sink   (input valid, status, task_id_out, priority_out, output ready);
endinterface

// File: design/active_expired_priority_queue.sv
// active_expired_priority_queue: two banks of per-level fifo queues under a small sequencer
// depends on aep_pkg and the channel interfaces in aep_if
//
//   channel   direction  handshake        payload
//   in_i      sink       valid / ready    command, task_id, dynamic_priority, reset_priority
//   out_o     source     valid / ready    status, task_id_out, priority_out
//   cfg       sink       cfg_we_i         cfg_wdata_i (level_count)
//
// one word in flight; in_i.ready is high only when the sequencer is idle
// add: head/fill read, store write, result; bad priority or empty get: result only
// get: scan, read, head, write, result; the scan takes 8 levels a cycle from the top
// out_o is a register, so a new word is taken while a result waits to be taken
// reset is asynchronous; queue store holds no reset, head/fill use valid bits
module active_expired_priority_queue #(
  parameter int MAX_LEVELS   = aep_pkg::MAX_LEVELS_DEF,
  parameter int QUEUE_DEPTH  = aep_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = aep_pkg::TASK_ID_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [aep_pkg::CFG_W-1:0] cfg_wdata_i,
  aep_in_if.sink                    in_i,
  aep_out_if.source                 out_o
);

  localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NCHUNK  = (MAX_LEVELS + 7) / 8;
  localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int NPAD    = NCHUNK * 8;
  localparam int META_AW = LVL_W + 1;
  localparam int META_N  = 2 ** META_AW;
  localparam int STORE_AW = META_AW + SLOT_W;
  localparam int STORE_N = 2 ** STORE_AW;
  localparam int META_W  = SLOT_W + FILL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_SCAN,
    S_GET_RD,
    S_GET_HEAD,
    S_GET_WR,
    S_EMIT
  } state_e;

  function automatic logic [3:0] top_set8(input logic [7:0] bits);
    logic [3:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) res = {1'b1, 3'(i)};
    end
    return res;
  endfunction

  state_e                     state_q;
  logic [aep_pkg::CFG_W-1:0]  level_count_q;
  logic                       active_q;
  logic                       bank_q;
  logic [LVL_W-1:0]           lvl_q;
  logic [CH_W-1:0]            chunk_q;
  logic [TASK_ID_BITS-1:0]    id_q;
  logic [1:0][NPAD-1:0]       ne_q;
  logic [META_N-1:0]          meta_vld_q;

  aep_pkg::status_e           res_status_q;
  logic [aep_pkg::ID_W-1:0]   res_id_q;
  logic [aep_pkg::OPRIO_W-1:0] res_prio_q;

  logic                       out_vld_q;
  aep_pkg::status_e           out_status_q;
  logic [aep_pkg::ID_W-1:0]   out_id_q;
  logic [aep_pkg::OPRIO_W-1:0] out_prio_q;

  logic [META_W-1:0]          meta_mem_q [META_N];
  logic [TASK_ID_BITS-1:0]    store_mem_q [STORE_N];
  logic [META_W-1:0]          meta_rdata_q;
  logic                       meta_rvld_q;
  logic [TASK_ID_BITS-1:0]    store_rdata_q;

  logic                       in_fire;
  logic                       out_free;
  logic [META_AW-1:0]         meta_addr;
  logic [SLOT_W-1:0]          cur_head;
  logic [FILL_W-1:0]          cur_fill;
  logic [FILL_W:0]            tail_sum;
  logic [SLOT_W-1:0]          tail;
  logic [SLOT_W-1:0]          head_nxt;
  logic                       meta_we;
  logic [META_W-1:0]          meta_wdata;
  logic                       store_we;
  logic [STORE_AW-1:0]        store_waddr;
  logic [STORE_AW-1:0]        store_raddr;
  logic [3:0]                 scan_hit;
  logic                       any_act;
  logic                       any_exp;
  logic                       is_expired;
  logic [aep_pkg::RPRIO_W-1:0] add_prio;
  logic                       add_bad;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_status_q;
  assign out_o.task_id_out  = out_id_q;
  assign out_o.priority_out = out_prio_q;

  // priority check on the incoming add word
  assign is_expired = (in_i.dynamic_priority == aep_pkg::DPRIO_EXPIRED);
  assign add_prio   = is_expired ? in_i.reset_priority
                                 : in_i.dynamic_priority[aep_pkg::RPRIO_W-1:0];
  assign add_bad    = (!is_expired && in_i.dynamic_priority[aep_pkg::DPRIO_W-1])
                      || ({1'b0, add_prio} >= level_count_q)
                      || (32'(add_prio) >= 32'(MAX_LEVELS));

  assign any_act = |ne_q[active_q];
  assign any_exp = |ne_q[!active_q];

  assign meta_addr = {bank_q, lvl_q};
  assign cur_head  = meta_rvld_q ? meta_rdata_q[META_W-1 -: SLOT_W] : '0;
  assign cur_fill  = meta_rvld_q ? meta_rdata_q[FILL_W-1:0] : '0;

  // tail slot with wrap, sum stays below twice the depth
  assign tail_sum = {1'b0, FILL_W'(cur_head)} + {1'b0, cur_fill};
  assign tail     = (32'(tail_sum) >= 32'(QUEUE_DEPTH))
                    ? SLOT_W'(tail_sum - (FILL_W + 1)'(QUEUE_DEPTH))
                    : SLOT_W'(tail_sum);
  assign head_nxt = (32'(cur_head) == 32'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

  assign store_raddr = {meta_addr, cur_head};
  assign store_waddr = {meta_addr, tail};
  assign scan_hit    = top_set8(ne_q[bank_q][chunk_q * 8 +: 8]);

  always_comb begin
    meta_we    = 1'b0;
    meta_wdata = {cur_head, cur_fill};
    store_we   = 1'b0;
    case (state_q)
      S_ADD_WR: begin
        if (32'(cur_fill) < 32'(QUEUE_DEPTH)) begin
          meta_we    = 1'b1;
          meta_wdata = {cur_head, cur_fill + 1'b1};
          store_we   = 1'b1;
        end
      end
      S_GET_WR: begin
        meta_we    = 1'b1;
        meta_wdata = {head_nxt, cur_fill - 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    meta_rdata_q  <= meta_mem_q[meta_addr];
    store_rdata_q <= store_mem_q[store_raddr];
    if (meta_we) meta_mem_q[meta_addr] <= meta_wdata;
    if (store_we) store_mem_q[store_waddr] <= id_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      level_count_q <= aep_pkg::LEVEL_COUNT_RST;
      active_q      <= 1'b0;
      bank_q        <= 1'b0;
      lvl_q         <= '0;
      chunk_q       <= '0;
      id_q          <= '0;
      ne_q          <= '0;
      meta_vld_q    <= '0;
      meta_rvld_q   <= 1'b0;
      res_status_q  <= aep_pkg::ST_EMPTY;
      res_id_q      <= '0;
      res_prio_q    <= '0;
      out_vld_q     <= 1'b0;
      out_status_q  <= aep_pkg::ST_EMPTY;
      out_id_q      <= '0;
      out_prio_q    <= '0;
    end else begin
      meta_rvld_q <= meta_vld_q[meta_addr];
      if (cfg_we_i) level_count_q <= cfg_wdata_i;
      if (out_vld_q && out_o.ready && state_q != S_EMIT) out_vld_q <= 1'b0;
      if (meta_we) meta_vld_q[meta_addr] <= 1'b1;

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            id_q       <= TASK_ID_BITS'(in_i.task_id);
            res_id_q   <= '0;
            res_prio_q <= '0;
            chunk_q    <= CH_W'(NCHUNK - 1);
            if (in_i.command == aep_pkg::CMD_ADD) begin
              bank_q <= is_expired ? !active_q : active_q;
              lvl_q  <= LVL_W'(add_prio);
              if (add_bad) begin
                res_status_q <= aep_pkg::ST_BADPRIO;
                state_q      <= S_EMIT;
              end else begin
                state_q <= S_ADD_RD;
              end
            end else begin
              if (!any_act && any_exp) begin
                active_q <= !active_q;
                bank_q   <= !active_q;
                state_q  <= S_SCAN;
              end else if (any_act) begin
                bank_q  <= active_q;
                state_q <= S_SCAN;
              end else begin
                res_status_q <= aep_pkg::ST_EMPTY;
                state_q      <= S_EMIT;
              end
            end
          end
        end
        S_ADD_RD: begin
          state_q <= S_ADD_WR;
        end
        S_ADD_WR: begin
          if (store_we) begin
            ne_q[bank_q][lvl_q] <= 1'b1;
            res_status_q        <= aep_pkg::ST_ADDED;
          end else begin
            res_status_q <= aep_pkg::ST_FULL;
          end
          state_q <= S_EMIT;
        end
        S_SCAN: begin
          if (scan_hit[3]) begin
            lvl_q   <= LVL_W'({chunk_q, scan_hit[2:0]});
            state_q <= S_GET_RD;
          end else begin
            chunk_q <= chunk_q - 1'b1;
          end
        end
        S_GET_RD: begin
          state_q <= S_GET_HEAD;
        end
        S_GET_HEAD: begin
          state_q <= S_GET_WR;
        end
        S_GET_WR: begin
          if (cur_fill == FILL_W'(1)) ne_q[bank_q][lvl_q] <= 1'b0;
          res_status_q <= aep_pkg::ST_DISPATCHED;
          res_id_q     <= aep_pkg::ID_W'(store_rdata_q);
          res_prio_q   <= aep_pkg::OPRIO_W'(lvl_q);
          state_q      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_status_q <= res_status_q;
            out_id_q     <= res_id_q;
            out_prio_q   <= res_prio_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: bench/active_expired_priority_queue_test.sv
`timescale 1ns / 1ps
// active_expired_priority_queue_test: self-checking bench for the two-bank task queue,
// directed add/get words then random phases over several level counts, checked in order
// depends on aep_pkg, the channel interfaces in aep_if and the rtl under design
module active_expired_priority_queue_test;
  import aep_pkg::*;

  typedef struct {
    status_e              status;
    logic [ID_W-1:0]      id;
    logic [OPRIO_W-1:0]   prio;
  } reply_t;

  class dispatch_tracker;
    logic [CFG_W-1:0] level_cnt;
    bit               act;
    logic [ID_W-1:0]  store [2][MAX_LEVELS_DEF][QUEUE_DEPTH_DEF];
    int               head  [2][MAX_LEVELS_DEF];
    int               fill  [2][MAX_LEVELS_DEF];
    int               count [2];
    reply_t           expected_replies [$];
    int               failures;

    function new();
      level_cnt = LEVEL_COUNT_RST;
      act = 1'b0;
      failures = 0;
      for (int b = 0; b < 2; b++) begin
        count[b] = 0;
        for (int l = 0; l < MAX_LEVELS_DEF; l++) begin
          head[b][l] = 0;
          fill[b][l] = 0;
        end
      end
    endfunction

    function void set_levels(logic [CFG_W-1:0] v);
      level_cnt = v;
    endfunction

    function int levels_in_use();
      return (int'(level_cnt) > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(level_cnt);
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    function status_e push_task(int bank, int lv, logic [ID_W-1:0] id);
      if (fill[bank][lv] >= QUEUE_DEPTH_DEF) return ST_FULL;
      store[bank][lv][(head[bank][lv] + fill[bank][lv]) % QUEUE_DEPTH_DEF] = id;
      fill[bank][lv]++;
      count[bank]++;
      return ST_ADDED;
    endfunction

    function void note_request(cmd_e cmd, logic [ID_W-1:0] id, logic [DPRIO_W-1:0] dyn,
                               logic [RPRIO_W-1:0] rp);
      reply_t r;
      int     levels;
      bit     found;
      levels = levels_in_use();
      r.status = ST_EMPTY;
      r.id = '0;
      r.prio = '0;
      found = 1'b0;
      if (cmd == CMD_ADD) begin
        if (dyn == DPRIO_EXPIRED) begin
          if (int'(rp) >= levels) r.status = ST_BADPRIO;
          else r.status = push_task(int'(!act), int'(rp), id);
        end else if (dyn[DPRIO_W-1] || int'(dyn) >= levels) begin
          r.status = ST_BADPRIO;
        end else begin
          r.status = push_task(int'(act), int'(dyn), id);
        end
      end else begin
        if (count[act] == 0 && count[!act] != 0) act = !act;
        if (count[act] != 0) begin
          for (int lv = MAX_LEVELS_DEF - 1; lv >= 0 && !found; lv--) begin
            if (fill[act][lv] != 0) begin
              r.id = store[act][lv][head[act][lv]];
              r.prio = OPRIO_W'(lv);
              head[act][lv] = (head[act][lv] + 1) % QUEUE_DEPTH_DEF;
              fill[act][lv]--;
              count[act]--;
              r.status = ST_DISPATCHED;
              found = 1'b1;
            end
          end
        end
      end
      expected_replies.push_back(r);
    endfunction

    function void check_reply(status_e st, logic [ID_W-1:0] id, logic [OPRIO_W-1:0] prio);
      reply_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result word: status %0d id %0h prio %0d", st, id, prio);
      end else begin
        want = expected_replies.pop_front();
        if (st !== want.status || id !== want.id || prio !== want.prio) begin
          failures++;
          if (failures <= 10)
            $display("result mismatch: expected status %0d id %0h prio %0d, got %0d %0h %0d",
                     want.status, want.id, want.prio, st, id, prio);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  bit               gaps_on;
  int               hold_request;
  dispatch_tracker  tracker;

  aep_in_if  in_if ();
  aep_out_if out_if ();

  active_expired_priority_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("** active_expired_priority_queue: FAILED **");
    $finish;
  end

  task automatic send_request(input cmd_e cmd, input logic [ID_W-1:0] id,
                              input logic [DPRIO_W-1:0] dyn, input logic [RPRIO_W-1:0] rp);
    if (gaps_on && $urandom_range(99) < 14) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.command          <= cmd;
    in_if.task_id          <= id;
    in_if.dynamic_priority <= dyn;
    in_if.reset_priority   <= rp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.note_request(cmd, id, dyn, rp);
  endtask

  task automatic write_level_count(input logic [CFG_W-1:0] v);
    in_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_levels(v);
  endtask

  task automatic send_random(input int add_pct);
    int                 eff;
    logic [DPRIO_W-1:0] dyn;
    logic [RPRIO_W-1:0] rp;
    int                 q;
    eff = tracker.levels_in_use();
    rp = RPRIO_W'($urandom_range(15));
    if ($urandom_range(99) < add_pct) begin
      q = $urandom_range(99);
      if (q < 20) begin
        dyn = DPRIO_EXPIRED;
        if (eff > 0 && $urandom_range(99) < 85) rp = RPRIO_W'($urandom_range(eff - 1));
      end else if (q < 27 || eff == 0) begin
        dyn = DPRIO_W'($urandom_range(31));
      end else begin
        dyn = DPRIO_W'($urandom_range(eff - 1));
      end
      send_request(CMD_ADD, ID_W'($urandom_range(255)), dyn, rp);
    end else begin
      send_request(CMD_GET, ID_W'($urandom_range(255)), DPRIO_W'($urandom_range(31)), rp);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        tracker.check_reply(out_if.status, out_if.task_id_out, out_if.priority_out);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= !(gaps_on && $urandom_range(99) < 14);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_levels [9];
    int               phase_items  [9];
    int               phase_adds   [9];
    tracker = new();
    gaps_on = 1'b1;
    hold_request = 0;
    phase_levels = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd2, 5'd12, 5'd16, 5'd4};
    phase_items  = '{260, 220, 260, 220, 60, 200, 220, 240, 170};
    phase_adds   = '{55, 70, 55, 50, 30, 65, 50, 45, 50};
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_wdata_i            <= '0;
    in_if.valid            <= 1'b0;
    in_if.command          <= CMD_ADD;
    in_if.task_id          <= '0;
    in_if.dynamic_priority <= '0;
    in_if.reset_priority   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty get, extremes, bad priorities, expired add, bank swap
    send_request(CMD_GET, 8'h00, 5'h00, 4'h0);
    send_request(CMD_ADD, 8'h00, 5'h00, 4'hF);
    send_request(CMD_ADD, 8'hFF, 5'h03, 4'h0);
    send_request(CMD_ADD, 8'hA5, 5'h04, 4'h1);
    send_request(CMD_ADD, 8'h11, 5'h10, 4'h1);
    send_request(CMD_ADD, 8'h22, 5'h0F, 4'h0);
    send_request(CMD_ADD, 8'h33, DPRIO_EXPIRED, 4'hF);
    send_request(CMD_ADD, 8'h5A, DPRIO_EXPIRED, 4'h2);
    send_request(CMD_GET, 8'hFF, 5'h1F, 4'hF);
    send_request(CMD_GET, 8'h00, 5'h00, 4'h0);
    send_request(CMD_GET, 8'h00, 5'h00, 4'h0);
    send_request(CMD_GET, 8'h00, 5'h00, 4'h0);
    send_request(CMD_ADD, 8'h3C, 5'h03, 4'h0);
    // zero levels rejects every add
    write_level_count(5'd0);
    send_request(CMD_ADD, 8'h01, 5'h00, 4'h0);
    send_request(CMD_ADD, 8'h02, DPRIO_EXPIRED, 4'h0);
    // lowered level count still dispatches what is queued
    write_level_count(5'd1);
    send_request(CMD_GET, 8'h00, 5'h00, 4'h0);
    send_request(CMD_GET, 8'h00, 5'h00, 4'h0);

    for (int p = 0; p < 9; p++) begin
      write_level_count(phase_levels[p]);
      gaps_on = (p != 6);
      if (p == 2) hold_request = 300;
      for (int n = 0; n < phase_items[p]; n++) send_random(phase_adds[p]);
    end
    gaps_on = 1'b1;

    in_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.failures == 0)
      $display("** active_expired_priority_queue: PASSED **");
    else
      $display("** active_expired_priority_queue: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
design/aep_pkg.sv
design/aep_if.sv
design/active_expired_priority_queue.sv
bench/active_expired_priority_queue_test.sv
